// File: hw/rtl/fxlms_pkg.sv
// Shared types, constants and the secondary-path coefficient table for the
// filtered-x LMS filter. Used by the cell row and by the top level.
`timescale 1ns / 1ps

package fxlms_pkg;

    localparam int TAPS  = 50;
    localparam int PATHS = 3;

    localparam int SMP_W = 16;
    localparam int STP_W = 15;
    localparam int TAP_W = $clog2(TAPS);
    localparam int PRD_W = 2 * SMP_W;
    localparam int ACC_W = PRD_W + TAP_W;
    localparam int UPD_W = 3 * SMP_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;
    localparam logic [STP_W-1:0] STEP_RESET = 15'd328;

    typedef logic signed [SMP_W-1:0] t_sample;

    typedef struct packed {
        logic ref_shift;
        logic ref_rot;
        logic filt_shift;
        logic filt_rot;
        logic w_rot;
    } t_cell_ctl;

    function automatic t_sample path_coef(input logic [1:0] row,
                                          input logic [TAP_W-1:0] k);
        t_sample c;
        c = '0;
        if (int'(row) < PATHS) begin
            if (row == 2'd0 && k == '0) begin
                c = 16'sd32767;
            end else if (row == 2'd1 && k == '0) begin
                c = 16'sd16384;
            end else if (row == 2'd1 && k == TAP_W'(1)) begin
                c = -16'sd16384;
            end
        end
        return c;
    endfunction

    function automatic t_sample clip_q30(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] v;
        hi = ACC_W'(32767) <<< 15;
        lo = -(ACC_W'(1) <<< 30);
        v  = acc;
        if (acc > hi) begin
            v = hi;
        end else if (acc < lo) begin
            v = lo;
        end
        return v[SMP_W+14:15];
    endfunction

endpackage

// File: hw/rtl/fxlms_cell.sv
// One tap cell: holds a reference sample, a filtered-reference sample and a
// weight, and passes them along the row. Depends on fxlms_pkg.
`timescale 1ns / 1ps

module fxlms_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fxlms_pkg::t_cell_ctl i_ctl,
    input  fxlms_pkg::t_sample  i_ref_prev,
    input  fxlms_pkg::t_sample  i_filt_prev,
    input  fxlms_pkg::t_sample  i_ref_next,
    input  fxlms_pkg::t_sample  i_filt_next,
    input  fxlms_pkg::t_sample  i_w_next,
    output fxlms_pkg::t_sample  o_ref,
    output fxlms_pkg::t_sample  o_filt,
    output fxlms_pkg::t_sample  o_w
);
    import fxlms_pkg::*;

    t_sample r_ref, r_filt, r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= '0;
            r_filt <= '0;
            r_w    <= '0;
        end else begin
            if (i_ctl.ref_shift) begin
                r_ref <= i_ref_prev;
            end else if (i_ctl.ref_rot) begin
                r_ref <= i_ref_next;
            end
            if (i_ctl.filt_shift) begin
                r_filt <= i_filt_prev;
            end else if (i_ctl.filt_rot) begin
                r_filt <= i_filt_next;
            end
            if (i_ctl.w_rot) begin
                r_w <= i_w_next;
            end
        end
    end

    assign o_ref  = r_ref;
    assign o_filt = r_filt;
    assign o_w    = r_w;

endmodule

// File: hw/rtl/fxlms_adaptive_filter.sv
// Top level of the filtered-x LMS filter: handshakes, sequencer, shared
// arithmetic and the row of tap cells. Depends on fxlms_pkg and fxlms_cell.
//
// An enabled transaction runs from acceptance to result as follows: the tap
// rows rotate past the shared arithmetic at cell 0, once for the
// secondary-path sum, then a step to store the filtered sample, then a weight
// update that per tap multiplies the step by the filtered sample, multiplies
// by the error and writes the weight, once for the output sum and a step to
// clip it. In bypass the result appears in the cycle after acceptance. A new
// input is taken only when idle with the output slot free or being emptied.
// Configuration writes are always accepted.
`timescale 1ns / 1ps

module fxlms_adaptive_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fxlms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fxlms_pkg::STP_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  fxlms_pkg::t_sample                 i_ref_sample,
    input  fxlms_pkg::t_sample                 i_err_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output fxlms_pkg::t_sample                 o_left_out,
    output fxlms_pkg::t_sample                 o_right_out
);
    import fxlms_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PATH = 6'b000010,
        S_FILT = 6'b000100,
        S_UPD  = 6'b001000,
        S_OUT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam logic [1:0] SUB_P1 = 2'd0;
    localparam logic [1:0] SUB_P2 = 2'd1;
    localparam logic [1:0] SUB_WR = 2'd2;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    t_state r_state;
    logic   r_enable;
    logic [1:0] r_path;
    logic [STP_W-1:0] r_step;
    logic [TAP_W-1:0] r_tap;
    logic [1:0] r_sub;
    t_sample r_e;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PRD_W-1:0] r_p1;
    logic signed [UPD_W-1:0] r_p2;
    logic r_out_valid;
    t_sample r_left, r_right;

    t_sample cell_ref  [TAPS];
    t_sample cell_filt [TAPS];
    t_sample cell_w    [TAPS];
    t_cell_ctl ctl;

    logic in_fire;
    logic last;
    logic signed [PRD_W-1:0] path_prod;
    logic signed [PRD_W-1:0] out_prod;
    logic signed [SMP_W+2:0] w_sum;
    t_sample w_new;
    t_sample filt_new;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign last        = (r_tap == LAST_TAP);

    assign path_prod = cell_ref[0] * path_coef(r_path, r_tap);
    assign out_prod  = cell_ref[0] * cell_w[0];
    assign filt_new  = clip_q30(r_acc);

    always_comb begin
        w_sum = (SMP_W+3)'(cell_w[0]) + (SMP_W+3)'($signed(r_p2[UPD_W-1:30]));
        if (w_sum > (SMP_W+3)'(32767)) begin
            w_new = 16'sd32767;
        end else if (w_sum < -(SMP_W+3)'(32768)) begin
            w_new = -16'sd32768;
        end else begin
            w_new = w_sum[SMP_W-1:0];
        end
    end

    always_comb begin
        ctl = '0;
        ctl.ref_shift  = in_fire && r_enable;
        ctl.ref_rot    = (r_state == S_PATH) || (r_state == S_OUT);
        ctl.filt_shift = (r_state == S_FILT);
        ctl.filt_rot   = (r_state == S_UPD) && (r_sub == SUB_WR);
        ctl.w_rot      = ((r_state == S_UPD) && (r_sub == SUB_WR)) || (r_state == S_OUT);
    end

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        t_sample ref_prev, filt_prev, ref_next, filt_next, w_next;
        if (i == 0) begin : g_head
            assign ref_prev  = i_ref_sample;
            assign filt_prev = filt_new;
        end else begin : g_body
            assign ref_prev  = cell_ref[i-1];
            assign filt_prev = cell_filt[i-1];
        end
        if (i == TAPS - 1) begin : g_tail
            assign ref_next  = cell_ref[0];
            assign filt_next = cell_filt[0];
            assign w_next    = (r_state == S_UPD) ? w_new : cell_w[0];
        end else begin : g_inner
            assign ref_next  = cell_ref[i+1];
            assign filt_next = cell_filt[i+1];
            assign w_next    = cell_w[i+1];
        end
        fxlms_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_ref_prev  (ref_prev),
            .i_filt_prev (filt_prev),
            .i_ref_next  (ref_next),
            .i_filt_next (filt_next),
            .i_w_next    (w_next),
            .o_ref       (cell_ref[i]),
            .o_filt      (cell_filt[i]),
            .o_w         (cell_w[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_path   <= '0;
            r_step   <= STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_PATH:   r_path   <= i_cfg_data[1:0];
                CFG_STEP:   r_step   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_sub       <= SUB_P1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_tap <= '0;
                        if (r_enable) begin
                            r_state <= S_PATH;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_PATH: begin
                    r_tap <= last ? '0 : r_tap + 1'b1;
                    if (last) begin
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    r_sub   <= SUB_P1;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    case (r_sub)
                        SUB_P1: r_sub <= SUB_P2;
                        SUB_P2: r_sub <= SUB_WR;
                        default: begin
                            r_sub <= SUB_P1;
                            r_tap <= last ? '0 : r_tap + 1'b1;
                            if (last) begin
                                r_state <= S_OUT;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    r_tap <= last ? '0 : r_tap + 1'b1;
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_e   <= i_err_sample;
            r_acc <= '0;
            if (!r_enable) begin
                r_left  <= i_ref_sample;
                r_right <= i_err_sample;
            end
        end
        case (r_state)
            S_PATH: r_acc <= r_acc + ACC_W'(path_prod);
            S_FILT: r_acc <= '0;
            S_UPD: begin
                if (r_sub == SUB_P1) begin
                    r_p1 <= $signed({1'b0, r_step}) * cell_filt[0];
                end else if (r_sub == SUB_P2) begin
                    r_p2 <= r_p1 * r_e;
                end
            end
            S_OUT: r_acc <= r_acc + ACC_W'(out_prod);
            S_DONE: begin
                r_left  <= filt_new;
                r_right <= filt_new;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

endmodule

// File: tb/fxlms_adaptive_filter_checker.sv
// Checker for the filtered-x LMS filter: watches the input, output and register
// channels, predicts each result and compares it. Depends on fxlms_pkg.
`timescale 1ns / 1ps

module fxlms_adaptive_filter_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [fxlms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fxlms_pkg::STP_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  fxlms_pkg::t_sample              i_ref_sample,
    input  fxlms_pkg::t_sample              i_err_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  fxlms_pkg::t_sample              i_left_out,
    input  fxlms_pkg::t_sample              i_right_out,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results
);
    import fxlms_pkg::*;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_drive;

    t_sample         ref_hist [TAPS];
    t_sample         filt_hist [TAPS];
    t_sample         coef [TAPS];
    logic            run_en;
    logic [1:0]      path_row;
    logic [STP_W-1:0] mu;
    t_drive          drive_q[$];

    function automatic longint path_gain(input logic [1:0] row, input int k);
        if (row == 2'd0 && k == 0) return 32767;
        if (row == 2'd1 && k == 0) return 16384;
        if (row == 2'd1 && k == 1) return -16384;
        return 0;
    endfunction

    function automatic t_sample sat_q15(input longint acc);
        longint v;
        v = acc;
        if (v > (longint'(32767) <<< 15)) v = longint'(32767) <<< 15;
        if (v < -(longint'(1) <<< 30)) v = -(longint'(1) <<< 30);
        return t_sample'(v >>> 15);
    endfunction

    task automatic predict_drive(input t_sample x, input t_sample e);
        longint acc;
        longint upd;
        longint w;
        t_drive d;
        if (!run_en) begin
            d.left = x;
            d.right = e;
        end else begin
            for (int k = TAPS - 1; k > 0; k--) ref_hist[k] = ref_hist[k-1];
            ref_hist[0] = x;
            acc = 0;
            for (int k = 0; k < TAPS; k++) acc += longint'(ref_hist[k]) * path_gain(path_row, k);
            for (int k = TAPS - 1; k > 0; k--) filt_hist[k] = filt_hist[k-1];
            filt_hist[0] = sat_q15(acc);
            for (int k = 0; k < TAPS; k++) begin
                upd = (longint'(mu) * longint'(filt_hist[k]) * longint'(e)) >>> 30;
                w = longint'(coef[k]) + upd;
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
                coef[k] = t_sample'(w);
            end
            acc = 0;
            for (int k = 0; k < TAPS; k++) acc += longint'(ref_hist[k]) * longint'(coef[k]);
            d.left = sat_q15(acc);
            d.right = d.left;
        end
        drive_q.push_back(d);
    endtask

    task automatic report(input string what, input int got, input int want);
        o_errors++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_drive d;
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                ref_hist[k] = '0;
                filt_hist[k] = '0;
                coef[k] = '0;
            end
            run_en = 1'b0;
            path_row = 2'd0;
            mu = STEP_RESET;
            drive_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (drive_q.size() == 0) begin
                    report("unexpected result", i_left_out, 0);
                end else begin
                    d = drive_q.pop_front();
                    if (i_left_out !== d.left) report("left_out", i_left_out, d.left);
                    if (i_right_out !== d.right) report("right_out", i_right_out, d.right);
                end
            end
            if (i_in_valid && i_in_ready) predict_drive(i_ref_sample, i_err_sample);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLE: run_en = i_cfg_data[0];
                    CFG_PATH:   path_row = i_cfg_data[1:0];
                    CFG_STEP:   mu = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = drive_q.size();
    end

endmodule

// File: tb/fxlms_adaptive_filter_test.sv
// Top of the filtered-x LMS filter testbench: clock, reset, register writes,
// sample stimulus with idling phases, and the verdict. Depends on fxlms_pkg,
// the filter and fxlms_adaptive_filter_checker.
`timescale 1ns / 1ps

module fxlms_adaptive_filter_test;
    import fxlms_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [STP_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    t_sample              ref_sample;
    t_sample              err_sample;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_sample              left_out;
    t_sample              right_out;
    int                   errors;
    int                   pending;
    int                   results;
    int                   idle_pct;
    int                   stall_pct;
    int                   hold_off = 0;
    logic                 hold_req;
    logic                 hold_seen = 1'b0;
    int                   sent;
    longint               cycles = 0;

    fxlms_adaptive_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_ref_sample(ref_sample), .i_err_sample(err_sample),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_left_out(left_out), .o_right_out(right_out)
    );

    fxlms_adaptive_filter_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_ref_sample(ref_sample), .i_err_sample(err_sample),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_left_out(left_out), .i_right_out(right_out),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_off <= 800;
            out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STP_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic send_pair(input t_sample x, input t_sample e);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        ref_sample <= x;
        err_sample <= e;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (220) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_sample'($urandom_range(200)) - 16'sd100;
            default: return t_sample'($urandom());
        endcase
    endfunction

    task automatic setup(input logic en, input logic [1:0] row, input logic [STP_W-1:0] mu);
        drain();
        write_reg(CFG_ENABLE, STP_W'(en));
        write_reg(CFG_PATH, STP_W'(row));
        write_reg(CFG_STEP, mu);
        if ($urandom_range(1)) write_reg(2'd3, STP_W'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        ref_sample = '0;
        err_sample = '0;
        hold_req = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bypass at reset, then the extremes of each path row and step size.
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(16'sh5555, -16'sd1);
        for (int row = 0; row < 4; row++) begin
            setup(1'b1, row[1:0], (row == 1) ? 15'h7fff : STEP_RESET);
            send_pair(16'sh7fff, 16'sh7fff);
            send_pair(16'sh8000, 16'sh7fff);
            send_pair(16'sh8000, 16'sh8000);
            send_pair(16'sh2aaa, 16'sh8000);
        end
        setup(1'b1, 2'd0, 15'd0);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh1234, 16'sh4321);

        // The output is held off while the sender keeps offering samples.
        setup(1'b1, 2'd1, 15'h7fff);
        hold_req = 1'b1;
        repeat (4) send_pair(rand_sample(), rand_sample());

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 60; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 60; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            setup((ph != 5), ph[1:0] ^ ph[2], (ph == 3) ? 15'h7fff : STP_W'($urandom()));
            repeat (100) send_pair(rand_sample(), rand_sample());
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
        $display("sent %0d sample pairs through bypass, every path row and both step extremes",
                 sent);
        $display("with idle and stall phases and a long output hold; %0d results checked",
                 results);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
